// ===== sv/urs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urs_pkg
// Shared types and constants of the ultrasonic range sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package urs_pkg;

    // register file index codes
    localparam logic [2:0] REG_TRIGGER_TICKS = 3'd0;
    localparam logic [2:0] REG_COUNT_CAP     = 3'd1;
    localparam logic [2:0] REG_TIMEOUT_ABOVE = 3'd2;
    localparam logic [2:0] REG_SCALE_Q16     = 3'd3;
    localparam logic [2:0] REG_FALLBACK_MM   = 3'd4;
    localparam logic [2:0] REG_RETRY_LIMIT   = 3'd5;

    // register reset values
    localparam logic [9:0]  RST_TRIGGER_TICKS = 10'd60;
    localparam logic [15:0] RST_COUNT_CAP     = 16'd35000;
    localparam logic [15:0] RST_TIMEOUT_ABOVE = 16'd34998;
    localparam logic [15:0] RST_SCALE_Q16     = 16'd2810;
    localparam logic [11:0] RST_FALLBACK_MM   = 12'd1500;
    localparam logic [1:0]  RST_RETRY_LIMIT   = 2'd1;

    // largest reportable distance
    localparam logic [11:0] DIST_MAX = 12'd4095;

    // sequencer phase codes
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_TRIG = 2'd1;
    localparam logic [1:0] PH_RISE = 2'd2;
    localparam logic [1:0] PH_MEAS = 2'd3;

    // configuration bundle from register file to core
    typedef struct packed {
        logic [9:0]  trigger_ticks;
        logic [15:0] count_cap;
        logic [15:0] timeout_above;
        logic [15:0] scale_q16;
        logic [11:0] fallback_mm;
        logic [1:0]  retry_limit;
    } urs_cfg_t;

endpackage

`default_nettype wire

// ===== sv/ultrasonic_range_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_range_sequencer
// Trigger/echo ranging sequencer for up to eight ultrasonic sensors.
// ----------------------------------------------------------------------------
// Each input transaction is one timer tick and produces exactly one result
// transaction. A tick passes an input register and a result register, so its
// result is presented from the result register, and one tick is taken every
// cycle as long as results are taken; the result register lets the next tick
// enter while a result waits. The longest path runs from the echo width counter
// through the count-times-scale multiplier into the result register. The user
// must write configuration over the APB port only while no measurement is
// running; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module ultrasonic_range_sequencer #(
    parameter int SENSOR_COUNT = 8,
    parameter int COUNT_BITS   = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // tick input
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_start_req,
    input  wire logic [3:0]  s_sensor_number,
    input  wire logic        s_echo_level,
    // result output
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [7:0]  m_trigger_lines,
    output logic             m_busy_res,
    output logic             m_done_res,
    output logic      [11:0] m_distance_mm,
    output logic             m_fell_back
);

    urs_pkg::urs_cfg_t cfg;

    // register file
    urs_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer
    urs_core #(
        .SENSOR_COUNT (SENSOR_COUNT),
        .COUNT_BITS   (COUNT_BITS)
    ) u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_start_req     (s_start_req),
        .s_sensor_number (s_sensor_number),
        .s_echo_level    (s_echo_level),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_trigger_lines (m_trigger_lines),
        .m_busy_res      (m_busy_res),
        .m_done_res      (m_done_res),
        .m_distance_mm   (m_distance_mm),
        .m_fell_back     (m_fell_back)
    );

endmodule

`default_nettype wire

// ===== sv/urs_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urs_cfg
// APB register file holding the ranging configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module urs_cfg (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [4:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    output urs_pkg::urs_cfg_t      cfg
);

    urs_pkg::urs_cfg_t cfg_reg;
    logic              wr_en;
    logic [2:0]        reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.trigger_ticks <= urs_pkg::RST_TRIGGER_TICKS;
            cfg_reg.count_cap     <= urs_pkg::RST_COUNT_CAP;
            cfg_reg.timeout_above <= urs_pkg::RST_TIMEOUT_ABOVE;
            cfg_reg.scale_q16     <= urs_pkg::RST_SCALE_Q16;
            cfg_reg.fallback_mm   <= urs_pkg::RST_FALLBACK_MM;
            cfg_reg.retry_limit   <= urs_pkg::RST_RETRY_LIMIT;
        end else if (wr_en) begin
            unique case (reg_idx)
                urs_pkg::REG_TRIGGER_TICKS: cfg_reg.trigger_ticks <= pwdata[9:0];
                urs_pkg::REG_COUNT_CAP:     cfg_reg.count_cap     <= pwdata[15:0];
                urs_pkg::REG_TIMEOUT_ABOVE: cfg_reg.timeout_above <= pwdata[15:0];
                urs_pkg::REG_SCALE_Q16:     cfg_reg.scale_q16     <= pwdata[15:0];
                urs_pkg::REG_FALLBACK_MM:   cfg_reg.fallback_mm   <= pwdata[11:0];
                urs_pkg::REG_RETRY_LIMIT:   cfg_reg.retry_limit   <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (reg_idx)
            urs_pkg::REG_TRIGGER_TICKS: prdata = {22'd0, cfg_reg.trigger_ticks};
            urs_pkg::REG_COUNT_CAP:     prdata = {16'd0, cfg_reg.count_cap};
            urs_pkg::REG_TIMEOUT_ABOVE: prdata = {16'd0, cfg_reg.timeout_above};
            urs_pkg::REG_SCALE_Q16:     prdata = {16'd0, cfg_reg.scale_q16};
            urs_pkg::REG_FALLBACK_MM:   prdata = {20'd0, cfg_reg.fallback_mm};
            urs_pkg::REG_RETRY_LIMIT:   prdata = {30'd0, cfg_reg.retry_limit};
            default:                    prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/urs_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urs_core
// Tick sequencer: input register, trigger/echo state machine, distance
// scaling and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module urs_core #(
    parameter int SENSOR_COUNT = 8,
    parameter int COUNT_BITS   = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire urs_pkg::urs_cfg_t cfg,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_start_req,
    input  wire logic [3:0]        s_sensor_number,
    input  wire logic              s_echo_level,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic      [7:0]        m_trigger_lines,
    output logic                   m_busy_res,
    output logic                   m_done_res,
    output logic      [11:0]       m_distance_mm,
    output logic                   m_fell_back
);

    localparam int SENSOR_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
    localparam int CMP_W    = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam int PROD_W   = COUNT_BITS + 16;

    // input register
    logic                  in_valid_reg;
    logic                  in_start_reg;
    logic [3:0]            in_sensor_reg;
    logic                  in_echo_reg;

    // sequencer state
    logic [1:0]            phase_reg, phase_next;
    logic [9:0]            trig_cnt_reg, trig_cnt_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [1:0]            retries_reg, retries_next;
    logic [SENSOR_W-1:0]   sensor_reg, sensor_next;
    logic                  echo_prev_reg;

    // result register
    logic                  out_valid_reg;
    logic [7:0]            trig_reg, trig_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [11:0]           dist_reg, dist_next;
    logic                  fell_reg, fell_next;

    logic                  advance;
    logic                  sensor_ok;
    logic [1:0]            ph;
    logic [9:0]            tlen;
    logic [9:0]            trig_inc;
    logic [CMP_W-1:0]      cap_ext;
    logic [CMP_W-1:0]      lim_ext;
    logic [CMP_W-1:0]      cmax_ext;
    logic [COUNT_BITS-1:0] count_max;
    logic [COUNT_BITS-1:0] count_eff;
    logic                  timed_out;
    logic [PROD_W-1:0]     prod;
    logic [CMP_W-1:0]      dist_ext;
    logic [11:0]           dist_sat;

    // handshake: the result register parts the two sides
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // effective limits
    assign tlen      = (cfg.trigger_ticks == 10'd0) ? 10'd1 : cfg.trigger_ticks;
    assign cap_ext   = CMP_W'(cfg.count_cap);
    assign lim_ext   = CMP_W'({COUNT_BITS{1'b1}});
    assign cmax_ext  = (cap_ext < lim_ext) ? cap_ext : lim_ext;
    assign count_max = cmax_ext[COUNT_BITS-1:0];
    assign sensor_ok = (in_sensor_reg != 4'd0)
                    && (32'(in_sensor_reg) <= 32'(SENSOR_COUNT));

    // zero count taken as one, then timeout test and scaling
    assign count_eff = (count_reg == '0) ? COUNT_BITS'(1) : count_reg;
    assign timed_out = CMP_W'(count_eff) > CMP_W'(cfg.timeout_above);
    assign prod      = PROD_W'(count_eff) * PROD_W'(cfg.scale_q16);
    assign dist_ext  = CMP_W'(prod[PROD_W-1:16]);
    assign dist_sat  = (dist_ext > CMP_W'(urs_pkg::DIST_MAX)) ? urs_pkg::DIST_MAX
                                                             : dist_ext[11:0];

    // per-tick step of the sequencer
    always_comb begin
        ph            = phase_reg;
        trig_cnt_next = trig_cnt_reg;
        count_next    = count_reg;
        retries_next  = retries_reg;
        sensor_next   = sensor_reg;
        trig_next     = 8'd0;
        busy_next     = 1'b0;
        done_next     = 1'b0;
        dist_next     = 12'd0;
        fell_next     = 1'b0;
        trig_inc      = 10'd0;

        // start request honored only when idle
        if (phase_reg == urs_pkg::PH_IDLE && in_start_reg && sensor_ok) begin
            sensor_next   = SENSOR_W'(in_sensor_reg - 4'd1);
            retries_next  = 2'd0;
            trig_cnt_next = 10'd0;
            count_next    = '0;
            ph            = urs_pkg::PH_TRIG;
        end
        phase_next = ph;

        unique case (ph)
            urs_pkg::PH_IDLE: begin
                phase_next = urs_pkg::PH_IDLE;
            end
            urs_pkg::PH_TRIG: begin
                trig_next = 8'd1 << sensor_next;
                busy_next = 1'b1;
                trig_inc  = trig_cnt_next + 10'd1;
                if (trig_inc >= tlen) begin
                    trig_cnt_next = 10'd0;
                    phase_next    = urs_pkg::PH_RISE;
                end else begin
                    trig_cnt_next = trig_inc;
                end
            end
            urs_pkg::PH_RISE: begin
                busy_next = 1'b1;
                if (in_echo_reg && !echo_prev_reg) begin
                    count_next = (count_max != '0) ? COUNT_BITS'(1) : '0;
                    phase_next = urs_pkg::PH_MEAS;
                end
            end
            urs_pkg::PH_MEAS: begin
                if (in_echo_reg) begin
                    busy_next = 1'b1;
                    if (count_reg < count_max) begin
                        count_next = count_reg + COUNT_BITS'(1);
                    end
                end else if (timed_out && (retries_reg < cfg.retry_limit)) begin
                    // no echo: trigger again
                    retries_next  = retries_reg + 2'd1;
                    trig_cnt_next = 10'd0;
                    count_next    = '0;
                    phase_next    = urs_pkg::PH_TRIG;
                    busy_next     = 1'b1;
                end else begin
                    done_next    = 1'b1;
                    fell_next    = timed_out;
                    dist_next    = timed_out ? cfg.fallback_mm : dist_sat;
                    retries_next = 2'd0;
                    count_next   = '0;
                    phase_next   = urs_pkg::PH_IDLE;
                end
            end
            default: begin
                phase_next = urs_pkg::PH_IDLE;
            end
        endcase
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_start_reg  <= s_start_req;
            in_sensor_reg <= s_sensor_number;
            in_echo_reg   <= s_echo_level;
        end
    end

    // sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= urs_pkg::PH_IDLE;
            trig_cnt_reg  <= 10'd0;
            count_reg     <= '0;
            retries_reg   <= 2'd0;
            sensor_reg    <= '0;
            echo_prev_reg <= 1'b0;
        end else if (advance) begin
            phase_reg     <= phase_next;
            trig_cnt_reg  <= trig_cnt_next;
            count_reg     <= count_next;
            retries_reg   <= retries_next;
            sensor_reg    <= sensor_next;
            echo_prev_reg <= in_echo_reg;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            trig_reg <= trig_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
            dist_reg <= dist_next;
            fell_reg <= fell_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_trigger_lines = trig_reg;
    assign m_busy_res      = busy_reg;
    assign m_done_res      = done_reg;
    assign m_distance_mm   = dist_reg;
    assign m_fell_back     = fell_reg;

    // a reported distance ends the measurement
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && done_reg) |-> !busy_reg)
        else $error("done reported while busy");

    // trigger drive only during a measurement and one-hot
    a_trig_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (trig_reg != 8'd0)) |-> (busy_reg && $onehot(trig_reg)))
        else $error("trigger drive outside a measurement");

    // echo count never passes its cap
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == urs_pkg::PH_MEAS) |-> (count_reg <= count_max))
        else $error("echo count above cap");

    // after a finished measurement the sequencer is idle
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && done_next) |=> (phase_reg == urs_pkg::PH_IDLE))
        else $error("sequencer not idle after report");

endmodule

`default_nettype wire
